/* hdl/hdr_pixel_tonemap_channel_view_macros.svh */
// Assertion helpers shared by the checker.
`ifndef HDR_PIXEL_TONEMAP_CHANNEL_VIEW_MACROS_SVH
`define HDR_PIXEL_TONEMAP_CHANNEL_VIEW_MACROS_SVH

// Consequent must hold in the same cycle.
`define HTM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the next cycle.
`define HTM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/htm_pkg.sv */
package htm_pkg;

  localparam int GAMMA_INDEX_BITS_DEF = 10;
  localparam int MAPPED_FRAC_BITS_DEF = 16;
  // remainder width of the Reinhard divider: denominator below 2^48, doubled
  localparam int DIV_W = 49;

  localparam logic [2:0] VIEW_RGBA  = 3'd0;
  localparam logic [2:0] VIEW_RGB   = 3'd1;
  localparam logic [2:0] VIEW_RED   = 3'd2;
  localparam logic [2:0] VIEW_GREEN = 3'd3;
  localparam logic [2:0] VIEW_BLUE  = 3'd4;
  localparam logic [2:0] VIEW_ALPHA = 3'd5;

  localparam logic [1:0] FLG_NONE = 2'd0;
  localparam logic [1:0] FLG_ZERO = 2'd1;
  localparam logic [1:0] FLG_FULL = 2'd2;
  localparam logic [1:0] FLG_SAT  = 2'd3;

  typedef struct packed {
    logic [31:0] red_bits;
    logic [31:0] green_bits;
    logic [31:0] blue_bits;
    logic [31:0] alpha_bits;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } pix_out_t;

  // v^11 * 32^g <= i^5 * 255^11, exact
  function automatic logic gamma_fits(input int v, input int i, input int g);
    logic [191:0] lhs;
    logic [191:0] rhs;
    lhs = 192'd1;
    rhs = 192'd1;
    for (int n = 0; n < 11; n++) begin
      lhs = lhs * 192'(v);
      rhs = rhs * 192'd255;
    end
    lhs = lhs << (5 * g);
    for (int n = 0; n < 5; n++) begin
      rhs = rhs * 192'(i);
    end
    return lhs <= rhs;
  endfunction

  // largest byte v with (v/255)^2.2 <= i/2^g
  function automatic logic [7:0] gamma_entry(input int i, input int g);
    int v;
    v = 0;
    for (int b = 7; b >= 0; b--) begin
      if (gamma_fits(v | (1 << b), i, g)) v = v | (1 << b);
    end
    return 8'(v);
  endfunction

endpackage

/* hdl/htm_color_lane.sv */
module htm_color_lane #(
  parameter int GAMMA_INDEX_BITS = htm_pkg::GAMMA_INDEX_BITS_DEF,
  parameter int MAPPED_FRAC_BITS = htm_pkg::MAPPED_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] bits_i,
  output logic [7:0]  byte_o
);
  import htm_pkg::*;

  localparam int G = GAMMA_INDEX_BITS;
  localparam int F = MAPPED_FRAC_BITS;
  localparam int ENTRIES = 1 << G;

  logic [7:0] rom [ENTRIES];

  for (genvar e = 0; e < ENTRIES; e++) begin : g_rom
    localparam logic [7:0] Val = gamma_entry(e, G);
    assign rom[e] = Val;
  end

  // decode
  logic [7:0]  expb;
  logic [22:0] frac;
  logic [23:0] sig;
  logic [7:0]  kexp;
  logic [1:0]  flag;

  assign expb = bits_i[30:23];
  assign frac = bits_i[22:0];
  assign sig  = {|expb, frac};
  assign kexp = (expb != 8'd0) ? (8'd150 - expb) : 8'd149;

  always_comb begin
    if (expb == 8'hFF) begin
      flag = ((frac != 23'd0) || bits_i[31]) ? FLG_ZERO : FLG_FULL;
    end else if (bits_i[31]) begin
      flag = FLG_ZERO;
    end else if ({1'b0, expb} >= 9'(127 + F)) begin
      flag = FLG_SAT;
    end else if (kexp >= 8'd48) begin
      flag = FLG_ZERO;
    end else begin
      flag = FLG_NONE;
    end
  end

  logic [DIV_W-1:0] rem_r  [F+1];
  logic [DIV_W-1:0] den_r  [F+1];
  logic [F-1:0]     quo_r  [F+1];
  logic [1:0]       flag_r [F+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= DIV_W'(sig);
      den_r[0]  <= DIV_W'(sig) + (DIV_W'(1) << kexp[5:0]);
      quo_r[0]  <= '0;
      flag_r[0] <= flag;
    end
  end

  // one quotient bit per stage
  for (genvar s = 0; s < F; s++) begin : g_div
    logic [DIV_W:0] dbl;
    logic [DIV_W:0] dif;
    logic           ge;
    assign dbl = {rem_r[s], 1'b0};
    assign dif = dbl - {1'b0, den_r[s]};
    assign ge  = dbl >= {1'b0, den_r[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= ge ? dif[DIV_W-1:0] : dbl[DIV_W-1:0];
        den_r[s+1]  <= den_r[s];
        quo_r[s+1]  <= {quo_r[s][F-2:0], ge};
        flag_r[s+1] <= flag_r[s];
      end
    end
  end

  logic [F-1:0]   mapped;
  logic [F+G-1:0] ext;
  logic [G-1:0]   idx;
  logic [7:0]     byte_r;

  assign mapped = (flag_r[F] == FLG_SAT) ? {F{1'b1}} : quo_r[F];
  assign ext    = {mapped, {G{1'b0}}};
  assign idx    = ext[F+G-1 -: G];

  always_ff @(posedge clk) begin
    if (en) begin
      case (flag_r[F])
        FLG_ZERO: byte_r <= 8'd0;
        FLG_FULL: byte_r <= 8'd255;
        default:  byte_r <= rom[idx];
      endcase
    end
  end

  assign byte_o = byte_r;

endmodule

/* hdl/htm_alpha_lane.sv */
module htm_alpha_lane #(
  parameter int DEPTH = htm_pkg::MAPPED_FRAC_BITS_DEF + 2
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] bits_i,
  output logic [7:0]  byte_o
);
  import htm_pkg::*;

  logic [7:0]  expb;
  logic [22:0] frac;
  logic [23:0] sig;
  logic [7:0]  kexp;
  logic [31:0] prod;
  logic [31:0] shifted;
  logic [7:0]  val;

  assign expb    = bits_i[30:23];
  assign frac    = bits_i[22:0];
  assign sig     = {|expb, frac};
  assign kexp    = (expb != 8'd0) ? (8'd150 - expb) : 8'd149;
  assign prod    = 32'(sig) * 32'd255;
  assign shifted = prod >> kexp[5:0];

  always_comb begin
    if ((expb == 8'hFF) && (frac != 23'd0)) begin
      val = 8'd0;
    end else if (bits_i[31]) begin
      val = 8'd0;
    end else if (expb >= 8'd127) begin
      val = 8'd255;
    end else if (kexp >= 8'd40) begin
      val = 8'd0;
    end else begin
      val = shifted[7:0];
    end
  end

  // match the color lanes
  logic [7:0] dly_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= val;
      for (int d = 1; d < DEPTH; d++) dly_r[d] <= dly_r[d-1];
    end
  end

  assign byte_o = dly_r[DEPTH-1];

endmodule

/* hdl/htm_view_merge.sv */
module htm_view_merge (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [2:0]        view_i,
  input  htm_pkg::pix_out_t pix_i,
  output logic              vld_o,
  output htm_pkg::pix_out_t pix_o
);
  import htm_pkg::*;

  pix_out_t pix_nxt;
  pix_out_t pix_r;
  logic     vld_r;

  always_comb begin
    pix_nxt = pix_i;
    case (view_i)
      VIEW_RGB:   pix_nxt.alpha_out = 8'd255;
      VIEW_RED:   pix_nxt = '{pix_i.red_out, pix_i.red_out, pix_i.red_out, 8'd255};
      VIEW_GREEN: pix_nxt = '{pix_i.green_out, pix_i.green_out, pix_i.green_out, 8'd255};
      VIEW_BLUE:  pix_nxt = '{pix_i.blue_out, pix_i.blue_out, pix_i.blue_out, 8'd255};
      VIEW_ALPHA: pix_nxt = '{pix_i.alpha_out, pix_i.alpha_out, pix_i.alpha_out, 8'd255};
      default:    pix_nxt = pix_i;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) pix_r <= pix_nxt;
  end

  assign vld_o = vld_r;
  assign pix_o = pix_r;

endmodule

/* hdl/hdr_pixel_tonemap_channel_view.sv */
// Throughput: one pixel per cycle unless out_stall holds the output; the Reinhard
//   divider is fully pipelined, one quotient bit per stage, in each of three
//   color lanes.
// The whole pipeline holds while a finished word waits under out_stall.
// Reset (rst_n, synchronous, active low) empties the pipeline and sets view to RGBA.
module hdr_pixel_tonemap_channel_view #(
  parameter int GAMMA_INDEX_BITS = htm_pkg::GAMMA_INDEX_BITS_DEF,
  parameter int MAPPED_FRAC_BITS = htm_pkg::MAPPED_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  htm_pkg::pix_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output htm_pkg::pix_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_data
);
  import htm_pkg::*;

  // decode, one stage per quotient bit, gamma table read
  localparam int LANE_LAT = MAPPED_FRAC_BITS + 2;

  logic       en;
  logic [2:0] view_r;
  logic [LANE_LAT-1:0] vld_r;
  pix_out_t   lane_pix;

  // advance everything unless the output word is held
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r <= VIEW_RGBA;
    end else if (cfg_valid) begin
      view_r <= cfg_data;
    end
  end

  // valid travels alongside the lane data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LANE_LAT-2:0], in_valid};
    end
  end

  htm_color_lane #(
    .GAMMA_INDEX_BITS(GAMMA_INDEX_BITS),
    .MAPPED_FRAC_BITS(MAPPED_FRAC_BITS)
  ) u_red (
    .clk(clk), .en(en), .bits_i(in_data.red_bits), .byte_o(lane_pix.red_out)
  );

  htm_color_lane #(
    .GAMMA_INDEX_BITS(GAMMA_INDEX_BITS),
    .MAPPED_FRAC_BITS(MAPPED_FRAC_BITS)
  ) u_green (
    .clk(clk), .en(en), .bits_i(in_data.green_bits), .byte_o(lane_pix.green_out)
  );

  htm_color_lane #(
    .GAMMA_INDEX_BITS(GAMMA_INDEX_BITS),
    .MAPPED_FRAC_BITS(MAPPED_FRAC_BITS)
  ) u_blue (
    .clk(clk), .en(en), .bits_i(in_data.blue_bits), .byte_o(lane_pix.blue_out)
  );

  htm_alpha_lane #(
    .DEPTH(LANE_LAT)
  ) u_alpha (
    .clk(clk), .en(en), .bits_i(in_data.alpha_bits), .byte_o(lane_pix.alpha_out)
  );

  // apply the channel view and hold the output word
  htm_view_merge u_merge (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(vld_r[LANE_LAT-1]), .view_i(view_r), .pix_i(lane_pix),
    .vld_o(out_valid), .pix_o(out_data)
  );

endmodule

/* hdl/htm_checker.sv */
`include "hdr_pixel_tonemap_channel_view_macros.svh"

module htm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input htm_pkg::pix_out_t out_data
);
  import htm_pkg::*;

  // output word waiting under out_stall
  logic held;

  assign held = out_valid && out_stall;

  `HTM_ASSERT_NOW(a_stall, clk, rst_n, in_stall, held, "input stalled without a held word")
  `HTM_ASSERT_NOW(a_block, clk, rst_n, held, in_stall, "input taken under a held word")
  `HTM_ASSERT_NEXT(a_hold, clk, rst_n, held, out_valid && $stable(out_data), "held word changed")

endmodule

bind hdr_pixel_tonemap_channel_view htm_checker u_htm_checker (.*);
